// ===== hdl/mvm_pkg.sv =====
// shared constants and types for the matrix-vector multiply block
`timescale 1ns / 1ps

package mvm_pkg;

  localparam int unsigned Dim = 16;
  localparam int unsigned DimW = (Dim > 1) ? $clog2(Dim) : 1;
  localparam int unsigned IndexW = 6;
  localparam int unsigned ValueW = 16;
  localparam int unsigned ProdW = 2 * ValueW;
  localparam int unsigned SumW = 38;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  typedef enum logic {
    CMD_VEC_WRITE = 1'b0,
    CMD_MAT_ELEM  = 1'b1
  } mvm_cmd_e;

  typedef struct packed {
    logic signed [ValueW-1:0] mat;
    logic signed [ValueW-1:0] vec;
    logic                     col_last;
    logic [IndexW-1:0]        row;
    logic                     row_last;
  } mvm_item_t;

endpackage

// ===== hdl/mvm_front.sv =====
// front end: takes transfers, holds the vector store and tracks row and column
`timescale 1ns / 1ps

module mvm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [5:0]         index_i,
  input  logic signed [15:0] value_i,
  output logic               item_valid_o,
  input  logic               item_stall_i,
  output mvm_pkg::mvm_item_t item_o
);
  import mvm_pkg::*;

  logic signed [ValueW-1:0] vector_store [Dim];

  logic            f_valid_q, f_valid_d;
  mvm_item_t       f_item_q;
  logic [DimW-1:0] col_q, col_d;
  logic [DimW-1:0] row_q, row_d;
  logic            f_ready;
  logic            accept;
  logic            is_mat;
  logic            col_last;
  logic            row_last;
  logic            vec_wr;

  assign f_ready    = !f_valid_q || !item_stall_i;
  assign in_stall_o = !f_ready;
  assign accept     = in_valid_i && f_ready;
  assign is_mat     = (mvm_cmd_e'(cmd_i) == CMD_MAT_ELEM);
  assign col_last   = (col_q == DimW'(Dim - 1));
  assign row_last   = (row_q == DimW'(Dim - 1));
  assign vec_wr     = accept && !is_mat && ({1'b0, index_i} < (IndexW + 1)'(Dim));

  always_comb begin
    f_valid_d = f_valid_q;
    col_d     = col_q;
    row_d     = row_q;
    if (f_ready) begin
      f_valid_d = accept && is_mat;
    end
    if (accept && is_mat) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      f_valid_q <= f_valid_d;
      col_q     <= col_d;
      row_q     <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vec_wr) begin
      vector_store[index_i[DimW-1:0]] <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_mat) begin
      f_item_q.mat      <= value_i;
      f_item_q.vec      <= vector_store[col_q];
      f_item_q.col_last <= col_last;
      f_item_q.row      <= IndexW'(row_q);
      f_item_q.row_last <= row_last;
    end
  end

  assign item_valid_o = f_valid_q;
  assign item_o       = f_item_q;

endmodule

// ===== hdl/mvm_queue.sv =====
// short queue between the front end and the multiply-accumulate back end
`timescale 1ns / 1ps

module mvm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_stall_o,
  input  mvm_pkg::mvm_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_stall_i,
  output mvm_pkg::mvm_item_t pop_item_o
);
  import mvm_pkg::*;

  mvm_item_t            entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 push;
  logic                 pop;

  assign push_stall_o = (count_q == QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;
  assign pop_item_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? QueuePtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? QueuePtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== hdl/mvm_back.sv =====
// back end: multiply, accumulate per row and hold the result register
`timescale 1ns / 1ps

module mvm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_stall_o,
  input  mvm_pkg::mvm_item_t item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         row_o,
  output logic signed [37:0] sum_o,
  output logic               last_row_o
);
  import mvm_pkg::*;

  logic                    p_valid_q, p_valid_d;
  logic signed [ProdW-1:0] p_prod_q;
  logic                    p_col_last_q;
  logic [IndexW-1:0]       p_row_q;
  logic                    p_row_last_q;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [SumW-1:0]  out_sum_q;
  logic [IndexW-1:0]       out_row_q;
  logic                    out_last_q;
  logic                    out_free;
  logic                    p_move;
  logic                    p_ready;
  logic                    take;
  logic                    load_out;
  logic signed [SumW-1:0]  sum_next;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign p_move       = p_valid_q && (!p_col_last_q || out_free);
  assign p_ready      = !p_valid_q || p_move;
  assign take         = item_valid_i && p_ready;
  assign item_stall_o = !p_ready;
  assign load_out     = p_move && p_col_last_q;
  assign sum_next     = sum_q + {{(SumW - ProdW){p_prod_q[ProdW-1]}}, p_prod_q};

  always_comb begin
    p_valid_d   = p_ready ? item_valid_i : p_valid_q;
    sum_d       = sum_q;
    if (p_move) begin
      sum_d = p_col_last_q ? '0 : sum_next;
    end
    out_valid_d = load_out || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      p_valid_q   <= p_valid_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      p_prod_q     <= item_i.mat * item_i.vec;
      p_col_last_q <= item_i.col_last;
      p_row_q      <= item_i.row;
      p_row_last_q <= item_i.row_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_sum_q  <= sum_next;
      out_row_q  <= p_row_q;
      out_last_q <= p_row_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_o       = out_row_q;
  assign sum_o       = out_sum_q;
  assign last_row_o  = out_last_q;

endmodule

// ===== hdl/matrix_vector_multiply.sv =====
// top level of the streaming matrix-vector multiply block
`timescale 1ns / 1ps

// usage:
// input channel: in_valid_i / in_stall_o with cmd_i, index_i, value_i.
//   cmd 0 writes value_i into vector entry index_i (indexes at or above the
//   dimension are dropped), cmd 1 streams the next matrix element in row-major
//   order. every vector entry must be written before use; unchecked.
// output channel: out_valid_o / out_stall_i with row_o, sum_o, last_row_o,
//   one transfer per completed row carrying the exact 38-bit dot product.
// throughput: one input transfer per cycle while out_stall_i is low,
//   vector writes and matrix elements alike; the front end, a four-entry queue
//   and the multiply and accumulate stages each take one item per cycle.
// result path: a row's last element passes from the front register through
//   the queue and the product register, then its sum enters the result register,
//   waiting longer where the queue or the result register is backed up.
// stall: a stalled result holds; the product stage, queue and front register
//   keep filling until full, then in_stall_o rises. nothing is dropped.
// reset: row, column and running sum return to zero; the vector store
//   keeps whatever it held and must be rewritten.
module matrix_vector_multiply (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [5:0]         index_i,
  input  logic signed [15:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         row_o,
  output logic signed [37:0] sum_o,
  output logic               last_row_o
);
  import mvm_pkg::*;

  logic      f_valid;
  logic      f_stall;
  mvm_item_t f_item;
  logic      q_valid;
  logic      q_stall;
  mvm_item_t q_item;

  mvm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .item_valid_o (f_valid),
    .item_stall_i (f_stall),
    .item_o       (f_item)
  );

  mvm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_stall_o (f_stall),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_stall_i  (q_stall),
    .pop_item_o   (q_item)
  );

  mvm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_stall_o (q_stall),
    .item_i       (q_item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_o        (row_o),
    .sum_o        (sum_o),
    .last_row_o   (last_row_o)
  );

  a_last_row_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_row_o == (row_o == IndexW'(Dim - 1))))
    else $error("last_row flag does not match row number");

  a_row_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, row_o} < (IndexW + 1)'(Dim)))
    else $error("result row beyond matrix dimension");

  a_queue_item_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid |-> (q_item.row_last == (q_item.row == IndexW'(Dim - 1))))
    else $error("queued item carries inconsistent row flags");

endmodule
